// File: hdl/csed_pkg.sv
package csed_pkg;

  localparam logic [3:0] PH_HEAD       = 4'd0;
  localparam logic [3:0] PH_ARG0       = 4'd1;
  localparam logic [3:0] PH_ARG_LAST   = 4'd7;
  localparam logic [3:0] PH_SIMPLE_ARG = 4'd8;
  localparam logic [3:0] PH_SIMPLE_END = 4'd11;
  localparam logic [3:0] PH_BYTES      = 4'd12;
  localparam logic [3:0] PH_TEXT       = 4'd13;
  localparam logic [3:0] PH_ERROR      = 4'd14;

  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  localparam logic [4:0] AI_ARG1     = 5'd24;
  localparam logic [4:0] AI_ARG8     = 5'd27;
  localparam logic [4:0] AI_RESERVED = 5'd28;
  localparam logic [4:0] AI_FALSE    = 5'd20;
  localparam logic [4:0] AI_TRUE     = 5'd21;
  localparam logic [4:0] AI_NULL     = 5'd22;

  localparam logic [3:0] EV_PAYLOAD = 4'd4;
  localparam logic [3:0] EV_SIMPLE  = 4'd8;
  localparam logic [3:0] EV_BOOL    = 4'd9;
  localparam logic [3:0] EV_NULL    = 4'd10;
  localparam logic [3:0] EV_UNDEF   = 4'd11;
  localparam logic [3:0] EV_HALF    = 4'd12;
  localparam logic [3:0] EV_ERROR   = 4'd15;

  localparam logic [63:0] ERR_RESERVED = 64'd0;
  localparam logic [63:0] ERR_TOO_LONG = 64'd1;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  arg_left;
    logic [63:0] acc;
    logic [31:0] pay_left;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
    logic        text;
  } event_t;

endpackage

// File: hdl/cbor_stream_event_decoder_core.sv
// CBOR stream event decoder.
// Input channel: one encoded byte per request on in_data_byte, in_valid/in_ready.
// Output channel: one event per request on out_event_kind, out_event_value,
// out_payload_last and out_payload_is_text, out_valid/out_ready.
// A byte is held in an input register, decoded combinationally against the
// parser state and its event, if any, lands in the output register. Argument
// bytes that only extend a pending head give no event.
// Throughput: one byte per cycle while the output is drained every cycle.
// A stalled receiver holds the event in the output register; the byte
// waiting behind it stays in the input register and in_ready drops only
// when both registers are full.
// A reserved or indefinite head, or an 8-byte string, array or map length,
// gives one error event; after it all bytes are accepted and dropped.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to head parsing.
module cbor_stream_event_decoder_core
  import csed_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [63:0] out_event_value,
  output logic        out_payload_last,
  output logic        out_payload_is_text
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  state_t     state_r;
  state_t     state_nxt;
  event_t     ev;
  event_t     out_r;
  logic       step_go;

  assign step_go  = in_valid_r && (!out_r.valid || out_ready);
  assign in_ready = !in_valid_r || step_go;

  csed_step u_step (
    .st        (state_r),
    .data_byte (in_byte_r),
    .nst       (state_nxt),
    .ev        (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_HEAD, arg_left: 4'd0, acc: 64'd0, pay_left: 32'd0};
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (step_go) begin
      out_r.valid <= ev.valid;
    end else if (out_ready) begin
      out_r.valid <= 1'b0;
    end
    if (step_go && ev.valid) begin
      out_r.kind  <= ev.kind;
      out_r.value <= ev.value;
      out_r.last  <= ev.last;
      out_r.text  <= ev.text;
    end
  end

  assign out_valid           = out_r.valid;
  assign out_event_kind      = out_r.kind;
  assign out_event_value     = out_r.value;
  assign out_payload_last    = out_r.last;
  assign out_payload_is_text = out_r.text;

  // error phase is sticky
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_ERROR |=> state_r.phase == PH_ERROR)
    else $error("error phase left before reset");

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload_last || out_payload_is_text) |-> out_event_kind == EV_PAYLOAD)
    else $error("payload flags on a non-payload event");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_BYTES || state_r.phase == PH_TEXT) |-> state_r.pay_left != 32'd0)
    else $error("payload phase with zero count");

  a_arg_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase >= PH_ARG0 && state_r.phase <= PH_SIMPLE_END) |-> state_r.arg_left != 4'd0)
    else $error("argument phase with zero count");

endmodule

// File: hdl/csed_step.sv
module csed_step
  import csed_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] data_byte,
  output state_t     nst,
  output event_t     ev
);

  logic [2:0]  mt;
  logic [4:0]  ai;
  logic        fin_go;
  logic [2:0]  fin_mt;
  logic [63:0] fin_arg;
  logic [63:0] acc_n;
  logic [3:0]  left_n;

  assign mt     = data_byte[7:5];
  assign ai     = data_byte[4:0];
  assign acc_n  = {st.acc[55:0], data_byte};
  assign left_n = st.arg_left - 4'd1;

  always_comb begin
    nst     = st;
    ev      = '0;
    fin_go  = 1'b0;
    fin_mt  = mt;
    fin_arg = {59'd0, ai};
    if (st.phase == PH_HEAD) begin
      if (ai >= AI_RESERVED) begin
        nst.phase = PH_ERROR;
        ev.valid  = 1'b1;
        ev.kind   = EV_ERROR;
        ev.value  = ERR_RESERVED;
      end else if (ai >= AI_ARG1) begin
        if (ai == AI_ARG8 && mt >= MT_BYTES && mt <= MT_MAP) begin
          nst.phase = PH_ERROR;
          ev.valid  = 1'b1;
          ev.kind   = EV_ERROR;
          ev.value  = ERR_TOO_LONG;
        end else begin
          nst.arg_left = 4'(4'd1 << ai[1:0]);
          nst.acc      = '0;
          if (mt == MT_SIMPLE) begin
            nst.phase = PH_SIMPLE_ARG + {2'd0, ai[1:0]};
          end else begin
            nst.phase = PH_ARG0 + {1'b0, mt};
          end
        end
      end else if (mt == MT_SIMPLE) begin
        ev.valid = 1'b1;
        if (ai < AI_FALSE) begin
          ev.kind  = EV_SIMPLE;
          ev.value = {59'd0, ai};
        end else if (ai == AI_FALSE) begin
          ev.kind = EV_BOOL;
        end else if (ai == AI_TRUE) begin
          ev.kind  = EV_BOOL;
          ev.value = 64'd1;
        end else if (ai == AI_NULL) begin
          ev.kind = EV_NULL;
        end else begin
          ev.kind = EV_UNDEF;
        end
      end else begin
        fin_go = 1'b1;
      end
    end else if (st.phase inside {[PH_ARG0:PH_SIMPLE_END]}) begin
      nst.acc      = acc_n;
      nst.arg_left = left_n;
      if (left_n == 4'd0) begin
        if (st.phase >= PH_SIMPLE_ARG) begin
          nst.phase = PH_HEAD;
          ev.valid  = 1'b1;
          ev.value  = acc_n;
          if (st.phase == PH_SIMPLE_ARG) begin
            ev.kind = EV_SIMPLE;
          end else begin
            ev.kind = EV_HALF + (st.phase - PH_SIMPLE_ARG - 4'd1);
          end
        end else begin
          fin_go  = 1'b1;
          fin_mt  = 3'(st.phase - PH_ARG0);
          fin_arg = acc_n;
        end
      end
    end else if (st.phase == PH_BYTES || st.phase == PH_TEXT) begin
      ev.valid = 1'b1;
      ev.kind  = EV_PAYLOAD;
      ev.value = {56'd0, data_byte};
      ev.text  = (st.phase == PH_TEXT);
      if (st.pay_left <= 32'd1) begin
        ev.last      = 1'b1;
        nst.pay_left = '0;
        nst.phase    = PH_HEAD;
      end else begin
        nst.pay_left = st.pay_left - 32'd1;
      end
    end

    if (fin_go) begin
      ev.valid = 1'b1;
      ev.value = fin_arg;
      if (fin_mt == MT_BYTES || fin_mt == MT_TEXT) begin
        ev.kind      = {1'b0, fin_mt};
        nst.pay_left = fin_arg[31:0];
        if (fin_arg != 64'd0) begin
          nst.phase = (fin_mt == MT_BYTES) ? PH_BYTES : PH_TEXT;
        end else begin
          nst.phase = PH_HEAD;
        end
      end else begin
        nst.phase = PH_HEAD;
        if (fin_mt <= 3'd1) begin
          ev.kind = {1'b0, fin_mt};
        end else begin
          ev.kind = {1'b0, fin_mt} + 4'd1;
        end
      end
    end
  end

endmodule

// File: dv/tb_cbor_stream_event_decoder_core.sv
`timescale 1ns / 100ps

module tb_cbor_stream_event_decoder_core;
  import csed_pkg::*;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NEGINT = 3'd1;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_TAG    = 3'd6;

  localparam logic [4:0] AI_ARG2  = 5'd25;
  localparam logic [4:0] AI_ARG4  = 5'd26;
  localparam logic [4:0] AI_UNDEF = 5'd23;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned BYTES_PER_PH = 500;
  localparam int unsigned DRAIN_CYCLES = 8;

  class cbor_event_scoreboard;
    logic [3:0]  phase    = PH_HEAD;
    logic [3:0]  arg_left = '0;
    logic [63:0] acc      = '0;
    logic [31:0] pay_left = '0;
    event_t      expected_events[$];
    int unsigned fail_count = 0;

    function void push_event(logic [3:0] kind, logic [63:0] value, logic last, logic text);
      event_t ev;
      ev.valid = 1'b1;
      ev.kind  = kind;
      ev.value = value;
      ev.last  = last;
      ev.text  = text;
      expected_events.push_back(ev);
    endfunction

    // Complete argument for major types 0..6.
    function void finish_head(logic [2:0] mt, logic [63:0] arg);
      if (mt == MT_BYTES || mt == MT_TEXT) begin
        pay_left = arg[31:0];
        if (arg != 0) phase = (mt == MT_BYTES) ? PH_BYTES : PH_TEXT;
        else phase = PH_HEAD;
        push_event({1'b0, mt}, arg, 1'b0, 1'b0);
      end else begin
        phase = PH_HEAD;
        // kinds 0,1 follow the major type; array, map and tag sit one above it
        if (mt <= MT_NEGINT) push_event({1'b0, mt}, arg, 1'b0, 1'b0);
        else push_event({1'b0, mt} + 4'd1, arg, 1'b0, 1'b0);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [2:0] mt;
      logic [4:0] ai;
      logic [3:0] ph;
      logic       last;
      mt = b[7:5];
      ai = b[4:0];
      ph = phase;
      if (ph == PH_HEAD) begin
        if (ai >= AI_RESERVED) begin
          phase = PH_ERROR;
          push_event(EV_ERROR, ERR_RESERVED, 1'b0, 1'b0);
        end else if (ai >= AI_ARG1) begin
          if (ai == AI_ARG8 && mt >= MT_BYTES && mt <= MT_MAP) begin
            phase = PH_ERROR;
            push_event(EV_ERROR, ERR_TOO_LONG, 1'b0, 1'b0);
          end else begin
            arg_left = 4'd1 << (ai - AI_ARG1);
            acc = '0;
            if (mt == MT_SIMPLE) phase = PH_SIMPLE_ARG + 4'(ai - AI_ARG1);
            else phase = PH_ARG0 + 4'(mt);
          end
        end else if (mt == MT_SIMPLE) begin
          if (ai < AI_FALSE) push_event(EV_SIMPLE, 64'(ai), 1'b0, 1'b0);
          else if (ai == AI_FALSE) push_event(EV_BOOL, 64'd0, 1'b0, 1'b0);
          else if (ai == AI_TRUE) push_event(EV_BOOL, 64'd1, 1'b0, 1'b0);
          else if (ai == AI_NULL) push_event(EV_NULL, 64'd0, 1'b0, 1'b0);
          else push_event(EV_UNDEF, 64'd0, 1'b0, 1'b0);
        end else begin
          finish_head(mt, 64'(ai));
        end
      end else if (ph >= PH_ARG0 && ph <= PH_SIMPLE_END) begin
        acc = {acc[55:0], b};
        arg_left = arg_left - 4'd1;
        if (arg_left == 0) begin
          if (ph >= PH_SIMPLE_ARG) begin
            phase = PH_HEAD;
            if (ph == PH_SIMPLE_ARG) push_event(EV_SIMPLE, acc, 1'b0, 1'b0);
            else push_event(EV_HALF + (ph - PH_SIMPLE_ARG - 4'd1), acc, 1'b0, 1'b0);
          end else begin
            finish_head(3'(ph - PH_ARG0), acc);
          end
        end
      end else if (ph == PH_BYTES || ph == PH_TEXT) begin
        last = (pay_left <= 1);
        if (last) begin
          pay_left = '0;
          phase = PH_HEAD;
        end else begin
          pay_left = pay_left - 1;
        end
        push_event(EV_PAYLOAD, 64'(b), last, ph == PH_TEXT);
      end
      // error phase: byte dropped
    endfunction

    function void check_event(logic [3:0] kind, logic [63:0] value, logic last, logic text);
      event_t ev;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event kind %0d value 0x%0h", $time, kind, value);
        fail_count++;
        return;
      end
      ev = expected_events.pop_front();
      if (ev.kind !== kind) begin
        $display("%0t: event_kind expected %0d, got %0d", $time, ev.kind, kind);
        fail_count++;
      end
      if (ev.value !== value) begin
        $display("%0t: event_value expected 0x%0h, got 0x%0h", $time, ev.value, value);
        fail_count++;
      end
      if (ev.last !== last) begin
        $display("%0t: payload_last expected %0b, got %0b", $time, ev.last, last);
        fail_count++;
      end
      if (ev.text !== text) begin
        $display("%0t: payload_is_text expected %0b, got %0b", $time, ev.text, text);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_kind;
  logic [63:0] out_event_value;
  logic        out_payload_last;
  logic        out_payload_is_text;

  cbor_event_scoreboard sb = new();

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned n_sent = 0;
  int unsigned cycles = 0;

  cbor_stream_event_decoder_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_kind      (out_event_kind),
    .out_event_value     (out_event_value),
    .out_payload_last    (out_payload_last),
    .out_payload_is_text (out_payload_is_text)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_event(out_event_kind, out_event_value, out_payload_last, out_payload_is_text);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    n_sent++;
  endtask

  // One well-formed item: head, argument bytes, string payload.
  task automatic send_item();
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [63:0] arg;
    int unsigned len;
    int          nbytes;
    mt = 3'($urandom_range(7));
    len = 0;
    if (mt == MT_BYTES || mt == MT_TEXT) begin
      len = ($urandom_range(39) == 0) ? $urandom_range(300) : $urandom_range(10);
      case ($urandom_range(3))
        0: ai = AI_ARG1;
        1: ai = AI_ARG2;
        2: ai = AI_ARG4;
        default: ai = (len < 24) ? 5'(len) : AI_ARG2;
      endcase
      if (ai == AI_ARG1 && len > 255) ai = AI_ARG2;
      arg = 64'(len);
    end else begin
      ai = 5'($urandom_range(27));
      if ((mt == MT_ARRAY || mt == MT_MAP) && ai == AI_ARG8) ai = AI_ARG4;
      case ($urandom_range(3))
        0: arg = '0;
        1: arg = '1;
        default: arg = {$urandom, $urandom};
      endcase
    end
    nbytes = (ai < AI_ARG1) ? 0 : (1 << (ai - AI_ARG1));
    send_byte({mt, ai});
    for (int i = nbytes - 1; i >= 0; i--) send_byte(arg[8*i +: 8]);
    if (nbytes != 0 && (mt == MT_BYTES || mt == MT_TEXT) || ai < AI_ARG1)
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Random bytes, kept clear of error heads and huge string lengths,
  // then run on until the parser is back at a head.
  task automatic send_noise(input int unsigned n);
    logic [7:0]  b;
    int unsigned k;
    k = 0;
    while (k < n || sb.phase != PH_HEAD) begin
      b = 8'($urandom);
      if (sb.phase == PH_HEAD) begin
        while (b[4:0] >= AI_RESERVED ||
               (b[4:0] == AI_ARG8 && b[7:5] >= MT_BYTES && b[7:5] <= MT_MAP))
          b = 8'($urandom);
      end else if ((sb.phase == PH_ARG0 + 4'(MT_BYTES) || sb.phase == PH_ARG0 + 4'(MT_TEXT))
                   && sb.arg_left > 1) begin
        b = 8'h00;
      end
      send_byte(b);
      k++;
    end
  endtask

  initial begin
    logic [7:0] directed_seq[$];
    logic [7:0] b;
    directed_seq = '{
      {MT_UINT, 5'd0}, {MT_UINT, 5'd23},
      {MT_NEGINT, AI_ARG8}, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      {MT_BYTES, 5'd0},
      {MT_TEXT, 5'd1}, 8'h7F,
      {MT_BYTES, AI_ARG1}, 8'h00,
      {MT_ARRAY, 5'd0}, {MT_MAP, 5'd0}, {MT_TAG, 5'd0},
      {MT_SIMPLE, 5'd0}, {MT_SIMPLE, AI_FALSE}, {MT_SIMPLE, AI_TRUE},
      {MT_SIMPLE, AI_NULL}, {MT_SIMPLE, AI_UNDEF},
      {MT_SIMPLE, AI_ARG1}, 8'hFF,
      {MT_SIMPLE, AI_ARG2}, 8'h80, 8'h01
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      // long receiver hold-off while requests keep coming
      if (p == 0) hold_asks++;
      while (n_sent < (p + 1) * BYTES_PER_PH) begin
        if ($urandom_range(6) == 0) send_noise($urandom_range(1, 6));
        else send_item();
      end
    end

    // sticky error last: one error event, then everything is dropped
    if ($urandom_range(1) != 0)
      b = {3'($urandom_range(7)), 5'($urandom_range(AI_RESERVED, 31))};
    else
      b = {3'($urandom_range(MT_BYTES, MT_MAP)), AI_ARG8};
    send_byte(b);
    repeat (8) send_byte(8'($urandom));
    in_valid <= 1'b0;
    stall_pct = 0;

    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
